// File: hw/rtl/ccrp_pkg.sv
// ----------------------------------------------------------------------------
// ccrp_pkg
// Types and constants shared by the membership record parser modules.
// ----------------------------------------------------------------------------
package ccrp_pkg;

  // format byte every record must start with
  localparam logic [7:0] FORMAT_VALUE = 8'd1;

  // field lengths in bytes
  localparam logic [3:0] VERSION_BYTES = 4'd8;
  localparam logic [3:0] COUNT_BYTES   = 4'd4;
  localparam logic [3:0] ID_BYTES      = 4'd4;
  localparam logic [3:0] LEN_BYTES     = 4'd2;

  // output queue geometry
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [2:0] {
    PH_FORMAT  = 3'd0,
    PH_VERSION = 3'd1,
    PH_COUNT   = 3'd2,
    PH_ID      = 3'd3,
    PH_VOTE    = 3'd4,
    PH_LEN     = 3'd5,
    PH_ADDR    = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_MEMBER = 2'd1,
    KIND_ADDR   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_FORMAT = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_TRAIL  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] cfg_version;
    logic [31:0] member_total;
    logic [31:0] member_id;
    logic        is_voter;
    logic [15:0] address_length;
    logic [7:0]  address_byte;
    status_t     status;
    logic        run_end;
  } result_t;

  // up to two results caused by one byte, packed from the first slot
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

// File: hw/rtl/ccrp_parser.sv
// ----------------------------------------------------------------------------
// ccrp_parser
// Byte-wise decoder state for the membership record; turns one byte into
// zero, one or two results.
// ----------------------------------------------------------------------------
module ccrp_parser
  import ccrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  input  logic         in_final,
  output result_pair_t res
);

  phase_t      phase, phase_next;
  logic [3:0]  idx, idx_next;
  logic [63:0] version, version_next;
  logic [31:0] count, count_next;
  logic [31:0] members_left, members_left_next;
  logic [31:0] member_id, member_id_next;
  logic        voter, voter_next;
  logic [15:0] addr_len, addr_len_next;
  logic [15:0] addr_left, addr_left_next;
  status_t     err, err_next;

  logic        ignoring;
  logic [3:0]  idx_inc;
  logic [31:0] members_dec;
  logic        emit_hdr;
  logic        emit_mem;
  logic        emit_addr;
  logic        emit_body;
  result_t     body_res;
  result_t     stat_res;
  status_t     final_status;

  // once an error is known past the header, bytes are dropped until the end
  assign ignoring    = (err != ST_OK) && (phase > PH_COUNT);
  assign idx_inc     = idx + 4'd1;
  assign members_dec = members_left - 32'd1;

  // field datapath
  always_comb begin
    idx_next          = idx;
    version_next      = version;
    count_next        = count;
    members_left_next = members_left;
    member_id_next    = member_id;
    voter_next        = voter;
    addr_len_next     = addr_len;
    addr_left_next    = addr_left;
    err_next          = err;
    if (!ignoring) begin
      unique case (phase)
        PH_FORMAT: begin
          if (in_byte != FORMAT_VALUE) begin
            err_next = ST_FORMAT;
          end
          idx_next = 4'd0;
        end
        PH_VERSION: begin
          version_next = {version[55:0], in_byte};
          idx_next     = (idx_inc >= VERSION_BYTES) ? 4'd0 : idx_inc;
        end
        PH_COUNT: begin
          count_next = {count[23:0], in_byte};
          idx_next   = (idx_inc >= COUNT_BYTES) ? 4'd0 : idx_inc;
          if (idx_inc >= COUNT_BYTES && err == ST_OK) begin
            members_left_next = {count[23:0], in_byte};
          end
        end
        PH_ID: begin
          member_id_next = {member_id[23:0], in_byte};
          idx_next       = (idx_inc >= ID_BYTES) ? 4'd0 : idx_inc;
        end
        PH_VOTE: begin
          voter_next = (in_byte != 8'd0);
          idx_next   = 4'd0;
        end
        PH_LEN: begin
          addr_len_next = {addr_len[7:0], in_byte};
          idx_next      = (idx_inc >= LEN_BYTES) ? 4'd0 : idx_inc;
          if (idx_inc >= LEN_BYTES) begin
            members_left_next = members_dec;
            addr_left_next    = {addr_len[7:0], in_byte};
          end
        end
        PH_ADDR: begin
          addr_left_next = addr_left - 16'd1;
          if (addr_left == 16'd1) begin
            idx_next = 4'd0;
          end
        end
        PH_DONE: begin
          err_next = ST_TRAIL;
        end
        default: begin
          err_next = err;
        end
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (!ignoring) begin
      unique case (phase)
        PH_FORMAT: phase_next = PH_VERSION;
        PH_VERSION: begin
          if (idx_inc >= VERSION_BYTES) begin
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (idx_inc >= COUNT_BYTES) begin
            if (err != ST_OK || {count[23:0], in_byte} == 32'd0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_ID;
            end
          end
        end
        PH_ID: begin
          if (idx_inc >= ID_BYTES) begin
            phase_next = PH_VOTE;
          end
        end
        PH_VOTE: phase_next = PH_LEN;
        PH_LEN: begin
          if (idx_inc >= LEN_BYTES) begin
            if ({addr_len[7:0], in_byte} != 16'd0) begin
              phase_next = PH_ADDR;
            end else if (members_dec == 32'd0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_ID;
            end
          end
        end
        PH_ADDR: begin
          if (addr_left == 16'd1) begin
            phase_next = (members_left == 32'd0) ? PH_DONE : PH_ID;
          end
        end
        PH_DONE: phase_next = PH_DONE;
        default: phase_next = phase;
      endcase
    end
  end

  // results
  always_comb begin
    emit_hdr  = !ignoring && (phase == PH_COUNT) && (idx_inc >= COUNT_BYTES)
                && (err == ST_OK);
    emit_mem  = !ignoring && (phase == PH_LEN) && (idx_inc >= LEN_BYTES);
    emit_addr = !ignoring && (phase == PH_ADDR);
    emit_body = emit_hdr || emit_mem || emit_addr;

    if (phase_next <= PH_COUNT) begin
      final_status = ST_SHORT;
    end else if (err_next != ST_OK) begin
      final_status = err_next;
    end else if (phase_next == PH_DONE) begin
      final_status = ST_OK;
    end else begin
      final_status = ST_TRUNC;
    end

    body_res         = '0;
    body_res.run_end = !in_final;
    if (emit_hdr) begin
      body_res.kind         = KIND_HEADER;
      body_res.cfg_version  = version;
      body_res.member_total = {count[23:0], in_byte};
    end else if (emit_mem) begin
      body_res.kind           = KIND_MEMBER;
      body_res.member_id      = member_id;
      body_res.is_voter       = voter;
      body_res.address_length = {addr_len[7:0], in_byte};
    end else begin
      body_res.kind         = KIND_ADDR;
      body_res.address_byte = in_byte;
    end

    stat_res         = '0;
    stat_res.kind    = KIND_STATUS;
    stat_res.status  = final_status;
    stat_res.run_end = 1'b1;

    res.second = stat_res;
    res.first  = emit_body ? body_res : stat_res;
    if (!in_valid) begin
      res.count = 2'd0;
    end else begin
      res.count = {1'b0, emit_body} + {1'b0, in_final};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_valid && in_final)) begin
      phase        <= PH_FORMAT;
      idx          <= 4'd0;
      version      <= 64'd0;
      count        <= 32'd0;
      members_left <= 32'd0;
      member_id    <= 32'd0;
      voter        <= 1'b0;
      addr_len     <= 16'd0;
      addr_left    <= 16'd0;
      err          <= ST_OK;
    end else if (in_valid) begin
      phase        <= phase_next;
      idx          <= idx_next;
      version      <= version_next;
      count        <= count_next;
      members_left <= members_left_next;
      member_id    <= member_id_next;
      voter        <= voter_next;
      addr_len     <= addr_len_next;
      addr_left    <= addr_left_next;
      err          <= err_next;
    end
  end

endmodule

// File: hw/rtl/ccrp_queue.sv
// ----------------------------------------------------------------------------
// ccrp_queue
// Small queue taking up to two results a cycle, handing out one on out_ready.
// ----------------------------------------------------------------------------
module ccrp_queue
  import ccrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  result_pair_t push,
  output logic         room,
  output logic         out_valid,
  output result_t      out_res,
  input  logic         out_ready
);

  result_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W-1:0]   tail;
  logic [QCNT_W-1:0]   fill;
  logic [QCNT_W-1:0]   fill_next;
  logic                pop;

  assign out_valid = (fill != '0);
  assign out_res   = mem[head];
  assign pop       = out_valid && out_ready;
  // space for a worst-case pair of results
  assign room      = (fill <= QCNT_W'(QUEUE_DEPTH - 2));

  assign fill_next = fill + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[tail] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[tail + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + QPTR_W'(push.count);
      if (pop) begin
        head <= head + QPTR_W'(1);
      end
      fill <= fill_next;
    end
  end

endmodule

// File: hw/rtl/cluster_config_record_parser.sv
// ----------------------------------------------------------------------------
// cluster_config_record_parser
// Streaming parser for a big-endian cluster membership record.
//
//   channel  dir  tdata                         tuser  tlast
//   s_       in   data_byte                     -      final_byte
//   m_       out  version/total/id/voter/len/   kind   run_end
//                 address byte/status
//
// one byte per cycle is taken while the queue has room; a byte that yields a
// result and the status on the final byte puts two results in the queue, drained
// one per cycle while m_tready is high. bytes pass the input register, then the queue.
// rst is synchronous and returns the parser to the format byte.
// a stalled output backs up the four-entry queue; with three results waiting
// and a byte held in the input register, s_tready drops.
// ----------------------------------------------------------------------------
module cluster_config_record_parser
  import ccrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // final_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,   // cfg_version, member_total, member_id, is_voter,
                                  // address_length, address_byte, status, zero pad
  output logic [1:0]   m_tuser,   // kind
  output logic         m_tlast    // run_end
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_final;
  logic         room;
  logic         consume;
  result_pair_t pair;
  result_t      head_res;

  assign consume  = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  ccrp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (consume),
    .in_byte  (in_byte),
    .in_final (in_final),
    .res      (pair)
  );

  ccrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pair),
    .room      (room),
    .out_valid (m_tvalid),
    .out_res   (head_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {4'b0, head_res.status, head_res.address_byte,
                    head_res.address_length, head_res.is_voter,
                    head_res.member_id, head_res.member_total,
                    head_res.cfg_version};
  assign m_tuser = head_res.kind;
  assign m_tlast = head_res.run_end;

endmodule

// File: tb/sv/ccrp_result_checker.sv
// ----------------------------------------------------------------------------
// ccrp_result_checker
// Watches both stream channels of the membership record parser. Every input
// transfer is decoded by a local model of the parser, and the results it
// yields are queued. Every output transfer is compared field by field with
// the oldest queued result.
// ----------------------------------------------------------------------------
module ccrp_result_checker
  import ccrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t      rec_phase;
  logic [3:0]  byte_idx;
  logic [63:0] ver_acc;
  logic [31:0] cnt_acc;
  logic [31:0] members_rem;
  logic [31:0] id_acc;
  logic        voter;
  logic [15:0] alen_acc;
  logic [15:0] addr_rem;
  status_t     err;

  result_t     decoded_q[$];
  result_t     got;
  result_t     want;
  int          mism = 0;

  assign fail_count = mism;

  task automatic restart();
    rec_phase   = PH_FORMAT;
    byte_idx    = '0;
    ver_acc     = '0;
    cnt_acc     = '0;
    members_rem = '0;
    id_acc      = '0;
    voter       = 1'b0;
    alen_acc    = '0;
    addr_rem    = '0;
    err         = ST_OK;
  endtask

  task automatic next_member();
    rec_phase = (members_rem == 0) ? PH_DONE : PH_ID;
    byte_idx  = '0;
  endtask

  function automatic result_t blank(kind_t k);
    result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  // model of one byte through the parser, queues up to two results
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    result_t out[2];
    int      n;
    logic    ignoring;
    n        = 0;
    ignoring = (err != ST_OK) && (rec_phase > PH_COUNT);
    if (!ignoring) begin
      case (rec_phase)
        PH_FORMAT: begin
          if (b != FORMAT_VALUE) err = ST_FORMAT;
          rec_phase = PH_VERSION;
          byte_idx  = '0;
        end
        PH_VERSION: begin
          ver_acc  = {ver_acc[55:0], b};
          byte_idx = byte_idx + 4'd1;
          if (byte_idx >= VERSION_BYTES) begin
            rec_phase = PH_COUNT;
            byte_idx  = '0;
          end
        end
        PH_COUNT: begin
          cnt_acc  = {cnt_acc[23:0], b};
          byte_idx = byte_idx + 4'd1;
          if (byte_idx >= COUNT_BYTES) begin
            byte_idx = '0;
            // a bad format byte suppresses the header result
            if (err != ST_OK) begin
              rec_phase = PH_DONE;
            end else begin
              out[n]              = blank(KIND_HEADER);
              out[n].cfg_version  = ver_acc;
              out[n].member_total = cnt_acc;
              n++;
              members_rem = cnt_acc;
              next_member();
            end
          end
        end
        PH_ID: begin
          id_acc   = {id_acc[23:0], b};
          byte_idx = byte_idx + 4'd1;
          if (byte_idx >= ID_BYTES) begin
            rec_phase = PH_VOTE;
            byte_idx  = '0;
          end
        end
        PH_VOTE: begin
          voter     = (b != 8'h00);
          rec_phase = PH_LEN;
          byte_idx  = '0;
        end
        PH_LEN: begin
          alen_acc = {alen_acc[7:0], b};
          byte_idx = byte_idx + 4'd1;
          if (byte_idx >= LEN_BYTES) begin
            out[n]                = blank(KIND_MEMBER);
            out[n].member_id      = id_acc;
            out[n].is_voter       = voter;
            out[n].address_length = alen_acc;
            n++;
            members_rem = members_rem - 32'd1;
            addr_rem    = alen_acc;
            if (addr_rem == 0) begin
              next_member();
            end else begin
              rec_phase = PH_ADDR;
              byte_idx  = '0;
            end
          end
        end
        PH_ADDR: begin
          out[n]              = blank(KIND_ADDR);
          out[n].address_byte = b;
          n++;
          addr_rem = addr_rem - 16'd1;
          if (addr_rem == 0) next_member();
        end
        default: begin
          err = ST_TRAIL;
        end
      endcase
    end
    if (fin) begin
      out[n] = blank(KIND_STATUS);
      if (rec_phase <= PH_COUNT) out[n].status = ST_SHORT;
      else if (err != ST_OK) out[n].status = err;
      else if (rec_phase == PH_DONE) out[n].status = ST_OK;
      else out[n].status = ST_TRUNC;
      n++;
      restart();
    end
    if (n > 0) out[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.insert(decoded_q.size(), out[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart();
      decoded_q.delete();
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.kind           = kind_t'(m_tuser);
        got.cfg_version    = m_tdata[63:0];
        got.member_total   = m_tdata[95:64];
        got.member_id      = m_tdata[127:96];
        got.is_voter       = m_tdata[128];
        got.address_length = m_tdata[144:129];
        got.address_byte   = m_tdata[152:145];
        got.status         = status_t'(m_tdata[155:153]);
        got.run_end        = m_tlast;
        if (decoded_q.size() == 0) begin
          mism++;
          if (mism <= 10)
            $display("unexpected result: kind %0d status %0d last %0b",
                     got.kind, got.status, got.run_end);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            mism++;
            if (mism <= 10)
              $display({"mismatch (exp/act): kind %0d/%0d ver %h/%h total %h/%h",
                        " id %h/%h voter %0b/%0b len %h/%h byte %h/%h",
                        " status %0d/%0d last %0b/%0b"},
                       want.kind, got.kind, want.cfg_version, got.cfg_version,
                       want.member_total, got.member_total,
                       want.member_id, got.member_id, want.is_voter, got.is_voter,
                       want.address_length, got.address_length,
                       want.address_byte, got.address_byte,
                       want.status, got.status, want.run_end, got.run_end);
          end
        end
      end
    end
    pending <= decoded_q.size();
  end

endmodule

// File: tb/sv/tb_cluster_config_record_parser.sv
// ----------------------------------------------------------------------------
// tb_cluster_config_record_parser
// Feeds membership records byte by byte into the parser: a few directed
// records, then mostly well-formed records with random content, mixed with
// cut, overlong, badly formatted and noisy ones. The sender idles in bursts,
// the receiver stalls at random and once holds off long enough to back up
// the input. Results are checked by the attached checker.
// ----------------------------------------------------------------------------
module tb_cluster_config_record_parser;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tready = 1'b0;
  wire          s_tready;
  wire          m_tvalid;
  wire  [159:0] m_tdata;
  wire  [1:0]   m_tuser;
  wire          m_tlast;
  int           fail_count;
  int           pending;

  logic [7:0]   rec_bytes[$];
  int           burst_left = 0;
  int           bytes_sent = 0;

  always #1 clk = ~clk;

  cluster_config_record_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  ccrp_result_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // one byte transfer, with a random gap before each new burst
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    rec_bytes.insert(rec_bytes.size(), b);
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_bytes.size(); i++)
      send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  task automatic put_be(input logic [63:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--) append_byte(v[8*i +: 8]);
  endtask

  task automatic build_record();
    int          pick;
    int          n_mem;
    int          alen;
    int          cut;
    logic [63:0] ver;
    logic [31:0] declared;
    logic [31:0] id;
    logic [7:0]  fmt;
    rec_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 92) begin
      repeat ($urandom_range(1, 16)) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 9))
      0: begin
        ver = '0;
      end
      1: begin
        ver = '1;
      end
      default: begin
        ver = {$urandom, $urandom};
      end
    endcase
    n_mem    = $urandom_range(0, 3);
    declared = n_mem;
    // count that the bytes present cannot satisfy
    if (pick >= 85)
      declared = $urandom_range(0, 1) ? $urandom : n_mem + $urandom_range(1, 3);
    fmt = ccrp_pkg::FORMAT_VALUE;
    if (pick >= 78 && pick < 85) begin
      fmt = 8'($urandom_range(0, 255));
      if (fmt == ccrp_pkg::FORMAT_VALUE) fmt = 8'h00;
    end
    append_byte(fmt);
    put_be(ver, 8);
    put_be(64'(declared), 4);
    for (int m = 0; m < n_mem; m++) begin
      case ($urandom_range(0, 7))
        0: begin
          id = '0;
        end
        1: begin
          id = '1;
        end
        default: begin
          id = $urandom;
        end
      endcase
      put_be(64'(id), 4);
      append_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      if ($urandom_range(0, 19) == 0) begin
        // random address length, with at most six address bytes after it
        alen = $urandom_range(0, 65535);
        put_be(64'(alen), 2);
        repeat ($urandom_range(0, 6)) append_byte(8'($urandom_range(0, 255)));
        break;
      end
      alen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 5);
      put_be(64'(alen), 2);
      repeat (alen) append_byte(8'($urandom_range(0, 255)));
    end
    if (pick >= 55 && pick < 67)
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(0, 255)));
    if (pick >= 67 && pick < 78) begin
      cut = $urandom_range(1, rec_bytes.size() - 1);
      while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
    end
  endtask

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: stall pattern changes per stretch, one long hold-off early on
  initial begin
    int cyc;
    int pct;
    int seg;
    bit held;
    cyc  = 0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      seg = $urandom_range(16, 160);
      pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(15, 90);
      repeat (seg) begin
        if (!held && cyc >= 400) begin
          m_tready <= 1'b0;
          repeat (300) @(posedge clk);
          held = 1'b1;
        end
        m_tready <= ($urandom_range(1, 100) <= pct);
        @(posedge clk);
        cyc++;
      end
    end
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // final on the format byte: short header
    rec_bytes.delete();
    append_byte(ccrp_pkg::FORMAT_VALUE);
    send_record();
    // all ones: bad format over a complete header
    rec_bytes.delete();
    repeat (13) append_byte(8'hFF);
    send_record();
    // zero version, no members
    rec_bytes.delete();
    append_byte(ccrp_pkg::FORMAT_VALUE);
    put_be(64'd0, 8);
    put_be(64'd0, 4);
    send_record();

    while (bytes_sent < 1150) begin
      build_record();
      send_record();
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
